// ===== hdl/rhc_pkg.sv =====
`default_nettype none

package rhc_pkg;

  // register stages from input to output register
  localparam int unsigned STG_NUM = 6;
  // stages of each divider
  localparam int unsigned DIV_STG = 4;
  localparam int unsigned QUO_W   = 16;

  localparam logic [7:0]  FULL_SCALE = 8'd255;
  // 65536 * 255
  localparam logic [23:0] QT_DEN     = 24'd16711680;

  typedef enum logic {
    CMD_HSV2RGB = 1'b0,
    CMD_RGB2HSV = 1'b1
  } cmd_e;

  // hue sextant, named by leading then middle (neither max nor min) channel
  typedef enum logic [2:0] {
    SEC_R_G = 3'd0,
    SEC_G_R = 3'd1,
    SEC_G_B = 3'd2,
    SEC_B_G = 3'd3,
    SEC_B_R = 3'd4,
    SEC_R_B = 3'd5
  } sector_e;

  typedef logic [STG_NUM-1:0] stg_en_t;

  // floor(x / 255), exact for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rhc_if.sv =====
`default_nettype none

interface rhc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;

  modport source (
    output valid, command, red, green, blue, hue, saturation, brightness,
    input  ready
  );
  modport sink (
    input  valid, command, red, green, blue, hue, saturation, brightness,
    output ready
  );
endinterface

interface rhc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [15:0] out_hue;
  logic [7:0]  out_saturation;
  logic [7:0]  out_brightness;

  modport source (
    output valid, out_red, out_green, out_blue, out_hue, out_saturation, out_brightness,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_hue, out_saturation, out_brightness,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/rhc_div.sv =====
`default_nettype none

// Pipelined restoring divider. Dividend bits of num_i are shifted in MSB
// first behind the starting remainder rem_i (which must be below den_i);
// quotient bits shift into the same register.
module rhc_div #(
  parameter int unsigned DW  = 8,
  parameter int unsigned QW  = 16,
  parameter int unsigned NST = 4
) (
  input  wire logic           clk_i,
  input  wire logic [NST-1:0] en_i,
  input  wire logic [DW-1:0]  rem_i,
  input  wire logic [QW-1:0]  num_i,
  input  wire logic [DW-1:0]  den_i,
  output logic      [QW-1:0]  quo_o
);

  localparam int unsigned STEP = QW / NST;

  logic [DW-1:0] rem_q [NST];
  logic [QW-1:0] acc_q [NST];
  logic [DW-1:0] den_q [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stg
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] acc_in;
    logic [DW-1:0] rem_d;
    logic [QW-1:0] acc_d;
    logic [DW:0]   r2;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign den_in = den_i;
      assign acc_in = num_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign acc_in = acc_q[k-1];
    end

    always_comb begin
      rem_d = rem_in;
      acc_d = acc_in;
      r2    = '0;
      for (int unsigned j = 0; j < STEP; j++) begin
        r2    = {rem_d, acc_d[QW-1]};
        acc_d = {acc_d[QW-2:0], 1'b0};
        if (r2 >= {1'b0, den_in}) begin
          r2       = r2 - {1'b0, den_in};
          acc_d[0] = 1'b1;
        end
        rem_d = r2[DW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d;
        acc_q[k] <= acc_d;
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = acc_q[NST-1];

endmodule

`default_nettype wire

// ===== hdl/rhc_r2h.sv =====
`default_nettype none

// RGB to HSV: max/min and hue numerator in the first stage, then two dividers.
module rhc_r2h (
  input  wire logic        clk_i,
  input  wire logic [4:0]  en_i,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  output logic      [15:0] hue_o,
  output logic      [7:0]  sat_o,
  output logic      [7:0]  bri_o
);

  import rhc_pkg::*;

  logic [7:0]  mx, mn, d;
  logic [10:0] d11, d6, n;
  logic [10:0] hden_d;
  logic [7:0]  sden_d;
  logic [15:0] snum_d;

  logic [10:0] hrem_q, hden_q;
  logic [15:0] snum_q;
  logic [7:0]  sden_q;
  logic [7:0]  mx_q [5];

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx)  mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn)  mn = blue_i;
    d   = mx - mn;
    d11 = {3'd0, d};
    d6  = (d11 << 2) + (d11 << 1);
    // red wins ties, then green
    if (mx == red_i) begin
      if (green_i >= blue_i) n = {3'd0, green_i - blue_i};
      else                   n = d6 - {3'd0, blue_i - green_i};
    end else if (mx == green_i) begin
      n = (d11 << 1) + {3'd0, blue_i} - {3'd0, red_i};
    end else begin
      n = (d11 << 2) + {3'd0, red_i} - {3'd0, green_i};
    end
    // grey and black give a zero dividend; keep the divisor nonzero
    hden_d = (d == 8'd0) ? 11'd1 : d6;
    sden_d = (mx == 8'd0) ? 8'd1 : mx;
    snum_d = {d, 8'd0} - {8'd0, d};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      hrem_q   <= n;
      hden_q   <= hden_d;
      snum_q   <= snum_d;
      sden_q   <= sden_d;
      mx_q[0]  <= mx;
    end
  end

  for (genvar k = 1; k < 5; k++) begin : g_mx
    always_ff @(posedge clk_i) begin
      if (en_i[k]) mx_q[k] <= mx_q[k-1];
    end
  end

  logic [QUO_W-1:0] squo;

  rhc_div #(.DW(11), .QW(QUO_W), .NST(DIV_STG)) u_hue_div (
    .clk_i (clk_i),
    .en_i  (en_i[4:1]),
    .rem_i (hrem_q),
    .num_i ('0),
    .den_i (hden_q),
    .quo_o (hue_o)
  );

  rhc_div #(.DW(8), .QW(QUO_W), .NST(DIV_STG)) u_sat_div (
    .clk_i (clk_i),
    .en_i  (en_i[4:1]),
    .rem_i (8'd0),
    .num_i (snum_q),
    .den_i (sden_q),
    .quo_o (squo)
  );

  // quotient never exceeds 255
  assign sat_o = squo[7:0];
  assign bri_o = mx_q[4];

endmodule

`default_nettype wire

// ===== hdl/rhc_h2r.sv =====
`default_nettype none

// HSV to RGB: sector/fraction, then f*s, then v*(1-..), then /255.
module rhc_h2r (
  input  wire logic        clk_i,
  input  wire logic [4:0]  en_i,
  input  wire logic [15:0] hue_i,
  input  wire logic [7:0]  sat_i,
  input  wire logic [7:0]  bri_i,
  output logic      [2:0]  sector_o,
  output logic      [7:0]  v_o,
  output logic      [7:0]  p_o,
  output logic      [7:0]  q_o,
  output logic      [7:0]  t_o
);

  import rhc_pkg::*;

  logic [18:0] six;
  logic [23:0] fs;
  logic [24:0] ft;
  logic [31:0] yq, yt;

  logic [2:0]  sec1_q, sec2_q, sec3_q, sec4_q, sec5_q;
  logic [7:0]  v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [15:0] frac1_q;
  logic [7:0]  s1_q;
  logic [15:0] pv1_q;
  logic [23:0] aq2_q;
  logic [24:0] at2_q;
  logic [7:0]  p2_q, p3_q, p4_q, p5_q;
  logic [15:0] yq3_q, yt3_q;
  logic [7:0]  q4_q, t4_q, q5_q, t5_q;

  assign six = {3'd0, hue_i} * 19'd6;
  assign fs  = {8'd0, frac1_q} * {16'd0, s1_q};
  assign ft  = (25'h10000 - {9'd0, frac1_q}) * {17'd0, s1_q};
  assign yq  = {24'd0, v2_q} * {8'd0, aq2_q};
  assign yt  = {24'd0, v2_q} * {8'd0, at2_q[23:0]};

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sec1_q  <= six[18:16];
      frac1_q <= six[15:0];
      v1_q    <= bri_i;
      s1_q    <= sat_i;
      pv1_q   <= {8'd0, bri_i} * {8'd0, FULL_SCALE - sat_i};
    end
    if (en_i[1]) begin
      sec2_q <= sec1_q;
      v2_q   <= v1_q;
      aq2_q  <= QT_DEN - fs;
      at2_q  <= {1'b0, QT_DEN} - ft;
      p2_q   <= div255(pv1_q);
    end
    if (en_i[2]) begin
      sec3_q <= sec2_q;
      v3_q   <= v2_q;
      p3_q   <= p2_q;
      yq3_q  <= yq[31:16];
      yt3_q  <= yt[31:16];
    end
    if (en_i[3]) begin
      sec4_q <= sec3_q;
      v4_q   <= v3_q;
      p4_q   <= p3_q;
      q4_q   <= div255(yq3_q);
      t4_q   <= div255(yt3_q);
    end
    if (en_i[4]) begin
      sec5_q <= sec4_q;
      v5_q   <= v4_q;
      p5_q   <= p4_q;
      q5_q   <= q4_q;
      t5_q   <= t4_q;
    end
  end

  assign sector_o = sec5_q;
  assign v_o      = v5_q;
  assign p_o      = p5_q;
  assign q_o      = q5_q;
  assign t_o      = t5_q;

endmodule

`default_nettype wire

// ===== hdl/rgb_hsv_color_converter_unit.sv =====
`default_nettype none

// Channel  | Dir | Payload
// req_i    | in  | command, red, green, blue, hue, saturation, brightness
// rsp_o    | out | out_red, out_green, out_blue, out_hue, out_saturation, out_brightness
//
// Six register stages; one item per cycle while rsp_o is not stalled.
// The two dividers of the RGB to HSV path (four stages of four quotient
// bits each) set the depth. Reset clears only the stage valid bits.
// Each stage loads when it is empty or the one after it moves, so a stall
// on rsp_o fills bubbles first; no item is dropped or repeated.
module rgb_hsv_color_converter_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rhc_in_if.sink      req_i,
  rhc_out_if.source   rsp_o
);

  import rhc_pkg::*;

  stg_en_t     en;
  stg_en_t     valid_q;
  cmd_e        cmd_q [STG_NUM-1];

  logic [15:0] hue_r;
  logic [7:0]  sat_r, bri_r;
  logic [2:0]  sector;
  logic [7:0]  hv, hp, hq, ht;
  logic [7:0]  r_d, g_d, b_d;

  logic [7:0]  out_red_q, out_green_q, out_blue_q;
  logic [15:0] out_hue_q;
  logic [7:0]  out_sat_q, out_bri_q;

  always_comb begin
    en[STG_NUM-1] = !valid_q[STG_NUM-1] || rsp_o.ready;
    for (int k = STG_NUM - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign req_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= req_i.valid;
      for (int k = 1; k < STG_NUM; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) cmd_q[0] <= cmd_e'(req_i.command);
    for (int k = 1; k < STG_NUM - 1; k++) begin
      if (en[k]) cmd_q[k] <= cmd_q[k-1];
    end
  end

  rhc_h2r u_h2r (
    .clk_i    (clk_i),
    .en_i     (en[STG_NUM-2:0]),
    .hue_i    (req_i.hue),
    .sat_i    (req_i.saturation),
    .bri_i    (req_i.brightness),
    .sector_o (sector),
    .v_o      (hv),
    .p_o      (hp),
    .q_o      (hq),
    .t_o      (ht)
  );

  rhc_r2h u_r2h (
    .clk_i   (clk_i),
    .en_i    (en[STG_NUM-2:0]),
    .red_i   (req_i.red),
    .green_i (req_i.green),
    .blue_i  (req_i.blue),
    .hue_o   (hue_r),
    .sat_o   (sat_r),
    .bri_o   (bri_r)
  );

  always_comb begin
    case (sector_e'(sector))
      SEC_R_G: begin r_d = hv; g_d = ht; b_d = hp; end
      SEC_G_R: begin r_d = hq; g_d = hv; b_d = hp; end
      SEC_G_B: begin r_d = hp; g_d = hv; b_d = ht; end
      SEC_B_G: begin r_d = hp; g_d = hq; b_d = hv; end
      SEC_B_R: begin r_d = ht; g_d = hp; b_d = hv; end
      default: begin r_d = hv; g_d = hp; b_d = hq; end
    endcase
  end

  // fields of the other direction read as zero
  always_ff @(posedge clk_i) begin
    if (en[STG_NUM-1]) begin
      if (cmd_q[STG_NUM-2] == CMD_RGB2HSV) begin
        out_red_q   <= 8'd0;
        out_green_q <= 8'd0;
        out_blue_q  <= 8'd0;
        out_hue_q   <= hue_r;
        out_sat_q   <= sat_r;
        out_bri_q   <= bri_r;
      end else begin
        out_red_q   <= r_d;
        out_green_q <= g_d;
        out_blue_q  <= b_d;
        out_hue_q   <= 16'd0;
        out_sat_q   <= 8'd0;
        out_bri_q   <= 8'd0;
      end
    end
  end

  assign rsp_o.valid          = valid_q[STG_NUM-1];
  assign rsp_o.out_red        = out_red_q;
  assign rsp_o.out_green      = out_green_q;
  assign rsp_o.out_blue       = out_blue_q;
  assign rsp_o.out_hue        = out_hue_q;
  assign rsp_o.out_saturation = out_sat_q;
  assign rsp_o.out_brightness = out_bri_q;

endmodule

`default_nettype wire
